>>> rtl/gsg_pkg.sv
package gsg_pkg;

    localparam int GOLD_LEN     = 31;
    localparam int OFFSET_STEPS = 1600;
    localparam int JUMP_CHUNK   = 32;

    typedef logic [GOLD_LEN-1:0] gold_word_t;
    typedef logic [GOLD_LEN-1:0][GOLD_LEN-1:0] jump_mat_t;

    // control from the handshake stage to the register pair
    typedef struct packed {
        logic advance;
        logic restart;
    } gsg_ctrl_t;

    // x1(n+31) = x1(n+3) ^ x1(n); bit i of the window holds x(n+i)
    function automatic gold_word_t step_a(input gold_word_t r);
        logic fb;
        fb = r[3] ^ r[0];
        return {fb, r[GOLD_LEN-1:1]};
    endfunction

    // x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
    function automatic gold_word_t step_b(input gold_word_t r);
        logic fb;
        fb = r[3] ^ r[2] ^ r[1] ^ r[0];
        return {fb, r[GOLD_LEN-1:1]};
    endfunction

    // offset jump run in chunks so that no single loop gets long at elaboration
    function automatic gold_word_t jump_a(input gold_word_t r_in);
        gold_word_t r;
        r = r_in;
        for (int c = 0; c < OFFSET_STEPS / JUMP_CHUNK; c++)
        begin
            for (int k = 0; k < JUMP_CHUNK; k++)
            begin
                r = step_a(r);
            end
        end
        for (int k = 0; k < OFFSET_STEPS % JUMP_CHUNK; k++)
        begin
            r = step_a(r);
        end
        return r;
    endfunction

    function automatic gold_word_t jump_b(input gold_word_t r_in);
        gold_word_t r;
        r = r_in;
        for (int c = 0; c < OFFSET_STEPS / JUMP_CHUNK; c++)
        begin
            for (int k = 0; k < JUMP_CHUNK; k++)
            begin
                r = step_b(r);
            end
        end
        for (int k = 0; k < OFFSET_STEPS % JUMP_CHUNK; k++)
        begin
            r = step_b(r);
        end
        return r;
    endfunction

    // register A start value after the offset jump, folded at elaboration
    function automatic gold_word_t calc_a_start();
        return jump_a(gold_word_t'(1));
    endfunction

    // rows of the jump matrix for register B: row j selects the seed bits
    // whose parity gives bit j of the jumped state
    function automatic jump_mat_t calc_b_rows();
        jump_mat_t  rows;
        gold_word_t r;
        rows = '0;
        for (int i = 0; i < GOLD_LEN; i++)
        begin
            r = jump_b(gold_word_t'(1) << i);
            for (int j = 0; j < GOLD_LEN; j++)
            begin
                rows[j][i] = r[j];
            end
        end
        return rows;
    endfunction

    localparam gold_word_t A_START     = calc_a_start();
    localparam jump_mat_t  JUMP_B_ROWS = calc_b_rows();

endpackage

>>> rtl/gsg_seed_jump.sv
module gsg_seed_jump (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                init_seed_we,
    input  gsg_pkg::gold_word_t init_seed,
    output gsg_pkg::gold_word_t b_start
);
    import gsg_pkg::*;

    gold_word_t b_start_reg;
    gold_word_t b_start_next;

    // jump is applied once at write time; each bit is a parity over the seed
    always_comb
    begin
        for (int j = 0; j < GOLD_LEN; j++)
        begin
            b_start_next[j] = ^(init_seed & JUMP_B_ROWS[j]);
        end
    end

    // a zero seed stays zero through the jump
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_start_reg <= '0;
        end
        else if (init_seed_we)
        begin
            b_start_reg <= b_start_next;
        end
    end

    assign b_start = b_start_reg;

endmodule

>>> rtl/gsg_lfsr_pair.sv
module gsg_lfsr_pair (
    input  logic                clk,
    input  logic                rst_n,
    input  gsg_pkg::gsg_ctrl_t  ctrl,
    input  gsg_pkg::gold_word_t b_start,
    output logic                cur_bit
);
    import gsg_pkg::*;

    gold_word_t a_reg;
    gold_word_t a_next;
    gold_word_t b_reg;
    gold_word_t b_next;
    gold_word_t a_cur;
    gold_word_t b_cur;

    // restart swaps in the pre-jumped start values before the bit is formed
    always_comb
    begin
        a_cur   = ctrl.restart ? A_START : a_reg;
        b_cur   = ctrl.restart ? b_start : b_reg;
        cur_bit = a_cur[0] ^ b_cur[0];
        a_next  = step_a(a_cur);
        b_next  = step_b(b_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= A_START;
            b_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

endmodule

>>> rtl/gold_sequence_generator.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    restart
// output    out_valid / out_ready  seq_bit
// config    init_seed_we           init_seed (31 bits, no read-back)
//
// One item per cycle sustained while out_ready stays high; out_valid rises
// once the item has passed the input register, then the result register.
// The LFSR pair advances only when an item moves into the result register.
// Reset gives the zero-seed sequence with both registers already jumped.
// A stalled output holds its bit; one more item fits in the input register,
// then in_ready stays low until the result register drains.
module gold_sequence_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                init_seed_we,
    input  gsg_pkg::gold_word_t init_seed,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                seq_bit
);
    import gsg_pkg::*;

    logic       s1_valid_reg;
    logic       s1_restart_reg;
    logic       out_valid_reg;
    logic       seq_bit_reg;
    logic       out_load;
    logic       cur_bit;
    gold_word_t b_start;
    gsg_ctrl_t  ctrl;

    assign out_load     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !s1_valid_reg || out_load;
    assign ctrl.advance = out_load;
    assign ctrl.restart = s1_restart_reg;

    gsg_seed_jump u_seed_jump (
        .clk          (clk),
        .rst_n        (rst_n),
        .init_seed_we (init_seed_we),
        .init_seed    (init_seed),
        .b_start      (b_start)
    );

    gsg_lfsr_pair u_lfsr_pair (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .b_start (b_start),
        .cur_bit (cur_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_restart_reg <= restart;
        end
        if (out_load)
        begin
            seq_bit_reg <= cur_bit;
        end
    end

    assign out_valid = out_valid_reg;
    assign seq_bit   = seq_bit_reg;

endmodule
